/* rtl/core/flood_duplicate_filter_forwarder_top_defines.svh */
// Assertion macros shared by the RTL of the duplicate filter.
// Build with ASSERT_OFF defined to drop every check.
`ifndef FLOOD_DUPLICATE_FILTER_FORWARDER_TOP_DEFINES_SVH
`define FLOOD_DUPLICATE_FILTER_FORWARDER_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define FDFF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define FDFF_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define FDFF_ASSERT(label, prop, msg)
`define FDFF_ASSERT_NEVER(label, expr, msg)
`endif
`endif

/* rtl/core/fdff_pkg.sv */
package fdff_pkg;

  localparam int DEFAULT_SEEN_DEPTH = 512;

  localparam logic [7:0]  VALID_MARKER = 8'hF1;
  localparam logic [15:0] MAX_PAYLOAD  = 16'd24;
  localparam logic [15:0] WORD_BYTES   = 16'd4;
  localparam logic [7:0]  MIN_HOP_FWD  = 8'd1;

  localparam logic KIND_RECV = 1'b0;
  localparam logic KIND_ORIG = 1'b1;

  typedef enum logic [1:0] {
    VERDICT_INVALID = 2'd0,
    VERDICT_DUP     = 2'd1,
    VERDICT_ACCEPT  = 2'd2,
    VERDICT_ORIG    = 2'd3
  } verdict_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  marker;
    logic [7:0]  hop_limit;
    logic [47:0] origin_addr;
    logic [47:0] dest_addr;
    logic [31:0] sequence_req;
    logic [15:0] frame_len;
    logic [31:0] payload_word;
  } in_payload_t;

  typedef struct packed {
    verdict_t    verdict;
    logic        deliver;
    logic [31:0] delivered_seq;
    logic        forward;
    logic [7:0]  forward_hop_limit;
    logic [31:0] duplicate_count;
  } out_payload_t;

  // One cache entry: origin and sequence pair
  typedef struct packed {
    logic [47:0] origin;
    logic [31:0] seq;
  } seen_entry_t;

endpackage

/* rtl/core/fdff_chan_if.sv */
interface fdff_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* rtl/core/fdff_seen_mem.sv */
module fdff_seen_mem #(
  parameter int SEEN_DEPTH = fdff_pkg::DEFAULT_SEEN_DEPTH,
  localparam int IW = $clog2(SEEN_DEPTH)
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [IW-1:0]         wr_addr,
  input  fdff_pkg::seen_entry_t wr_data,
  input  logic                  rd_en,
  input  logic [IW-1:0]         rd_addr,
  output fdff_pkg::seen_entry_t rd_data
);

  fdff_pkg::seen_entry_t mem [SEEN_DEPTH];

  // Write one slot
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/fdff_scan_ctrl.sv */
`include "flood_duplicate_filter_forwarder_top_defines.svh"

module fdff_scan_ctrl #(
  parameter int SEEN_DEPTH = fdff_pkg::DEFAULT_SEEN_DEPTH,
  localparam int IW = $clog2(SEEN_DEPTH)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [47:0]           own_addr,
  fdff_chan_if.sink             in_req,
  fdff_chan_if.source           out_rsp,
  output logic                  mem_wr_en,
  output logic [IW-1:0]         mem_wr_addr,
  output fdff_pkg::seen_entry_t mem_wr_data,
  output logic                  mem_rd_en,
  output logic [IW-1:0]         mem_rd_addr,
  input  fdff_pkg::seen_entry_t mem_rd_data
);

  localparam int FW = $clog2(SEEN_DEPTH + 1);
  localparam logic [FW-1:0] FillFull = FW'(SEEN_DEPTH);
  localparam logic [IW-1:0] LastSlot = IW'(SEEN_DEPTH - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_STORE,
    S_FINISH
  } state_t;

  state_t                 state;
  fdff_pkg::in_payload_t  item;
  fdff_pkg::verdict_t     verdict_q;
  logic [FW-1:0]          fill_count;
  logic [IW-1:0]          replace_ptr;
  logic [31:0]            duplicate_total;
  logic [IW-1:0]          scan_addr;
  logic                   scan_more;
  logic                   rd_pend;
  logic                   rd_last;
  logic                   out_valid;
  fdff_pkg::out_payload_t out_q;

  logic                   in_fire;
  logic                   item_bad;
  logic                   cache_full;
  logic [IW-1:0]          last_idx;
  logic                   issue_last;
  logic                   hit;
  logic [IW-1:0]          store_slot;
  logic                   out_free;
  logic                   deliver;
  logic                   forward;
  fdff_pkg::out_payload_t result;

  assign in_req.ready    = (state == S_IDLE);
  assign in_fire         = in_req.valid && in_req.ready;
  assign out_rsp.valid   = out_valid;
  assign out_rsp.payload = out_q;

  // Judge the incoming request header
  assign item_bad = (in_req.payload.marker != fdff_pkg::VALID_MARKER) ||
                    (in_req.payload.frame_len > fdff_pkg::MAX_PAYLOAD);

  // Scan bookkeeping: the shared comparator checks one stored pair a cycle
  assign cache_full = (fill_count == FillFull);
  assign last_idx   = IW'(fill_count - FW'(1));
  assign issue_last = (scan_addr == last_idx);
  assign hit        = rd_pend && (mem_rd_data.origin == item.origin_addr) &&
                      (mem_rd_data.seq == item.sequence_req);

  assign mem_rd_en   = (state == S_SCAN) && scan_more;
  assign mem_rd_addr = scan_addr;

  // Pick the slot: fill in order, then overwrite at the wrapping pointer
  assign store_slot  = cache_full ? replace_ptr : IW'(fill_count);
  assign mem_wr_en   = (state == S_STORE);
  assign mem_wr_addr = store_slot;
  assign mem_wr_data = '{origin: item.origin_addr, seq: item.sequence_req};

  // Build the result
  assign out_free = !out_valid || out_rsp.ready;
  assign deliver  = (verdict_q == fdff_pkg::VERDICT_ACCEPT) &&
                    (item.dest_addr == own_addr) &&
                    (item.frame_len >= fdff_pkg::WORD_BYTES);
  assign forward  = (verdict_q == fdff_pkg::VERDICT_ACCEPT) &&
                    (item.hop_limit > fdff_pkg::MIN_HOP_FWD);

  always_comb begin
    result.verdict           = verdict_q;
    result.deliver           = deliver;
    result.delivered_seq     = deliver ? item.payload_word : 32'd0;
    result.forward           = forward;
    result.forward_hop_limit = forward ? (item.hop_limit - 8'd1) : 8'd0;
    result.duplicate_count   = duplicate_total;
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      verdict_q       <= fdff_pkg::VERDICT_INVALID;
      fill_count      <= '0;
      replace_ptr     <= '0;
      duplicate_total <= '0;
      scan_addr       <= '0;
      scan_more       <= 1'b0;
      rd_pend         <= 1'b0;
      rd_last         <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (out_valid && out_rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            item      <= in_req.payload;
            scan_addr <= '0;
            scan_more <= 1'b1;
            rd_pend   <= 1'b0;
            if (in_req.payload.kind == fdff_pkg::KIND_ORIG) begin
              verdict_q <= fdff_pkg::VERDICT_ORIG;
              state     <= S_STORE;
            end else if (item_bad) begin
              verdict_q <= fdff_pkg::VERDICT_INVALID;
              state     <= S_FINISH;
            end else if (fill_count == '0) begin
              verdict_q <= fdff_pkg::VERDICT_ACCEPT;
              state     <= S_STORE;
            end else begin
              verdict_q <= fdff_pkg::VERDICT_ACCEPT;
              state     <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // Issue the next read, compare the one returned
          if (scan_more) begin
            scan_addr <= scan_addr + IW'(1);
            scan_more <= !issue_last;
            rd_pend   <= 1'b1;
            rd_last   <= issue_last;
          end else begin
            rd_pend <= 1'b0;
          end
          if (hit) begin
            verdict_q       <= fdff_pkg::VERDICT_DUP;
            duplicate_total <= duplicate_total + 32'd1;
            scan_more       <= 1'b0;
            rd_pend         <= 1'b0;
            state           <= S_FINISH;
          end else if (rd_pend && rd_last) begin
            state <= S_STORE;
          end
        end
        S_STORE: begin
          if (cache_full) begin
            replace_ptr <= (replace_ptr == LastSlot) ? '0 : replace_ptr + IW'(1);
          end else begin
            fill_count <= fill_count + FW'(1);
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          // Hold until the output register frees up
          if (out_free) begin
            out_q     <= result;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `FDFF_ASSERT(a_fill_bound, fill_count <= FillFull, "fill count above cache depth")
  `FDFF_ASSERT(a_ptr_until_full, fill_count < FillFull |-> replace_ptr == '0, "pointer moved early")
  `FDFF_ASSERT(a_out_from_finish, $rose(out_valid) |-> $past(state == S_FINISH), "stray result")
  `FDFF_ASSERT_NEVER(a_pend_outside_scan, rd_pend && (state != S_SCAN), "read pending off scan")
  `FDFF_ASSERT(a_dup_step, $past(!rst) && (duplicate_total != $past(duplicate_total)) |-> (duplicate_total == $past(duplicate_total) + 32'd1) && (verdict_q == fdff_pkg::VERDICT_DUP), "duplicate count jump")

endmodule

/* rtl/core/flood_duplicate_filter_forwarder_top.sv */
// Channel   Role    Handshake       Payload
// in_req    sink    valid / ready   fdff_pkg::in_payload_t  (one request per frame)
// out_rsp   source  valid / ready   fdff_pkg::out_payload_t (one result per request)
// cfg_wr_*  write   enable / data   own_addr, 48 bits
//
// A received frame that gets stored waits for the scan of the seen cache, one stored
// pair per cycle through one comparator, before the next request is accepted; with
// an empty cache no scan runs, and a duplicate found in slot k ends the scan there.
// Rejected frames and originate requests skip the scan. No new request is taken
// until the last result is in the output register. Synchronous reset empties the cache
// through its fill count; a stalled output holds the sequencer in its last step, one result may wait.
module flood_duplicate_filter_forwarder_top #(
  parameter int SEEN_DEPTH = fdff_pkg::DEFAULT_SEEN_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [47:0] cfg_wr_data,
  fdff_chan_if.sink   in_req,
  fdff_chan_if.source out_rsp
);

  localparam int IW = $clog2(SEEN_DEPTH);

  logic [47:0]           own_addr;
  logic                  mem_wr_en;
  logic [IW-1:0]         mem_wr_addr;
  fdff_pkg::seen_entry_t mem_wr_data;
  logic                  mem_rd_en;
  logic [IW-1:0]         mem_rd_addr;
  fdff_pkg::seen_entry_t mem_rd_data;

  // Hold the node address
  always_ff @(posedge clk) begin
    if (rst) begin
      own_addr <= '0;
    end else if (cfg_wr_en) begin
      own_addr <= cfg_wr_data;
    end
  end

  fdff_scan_ctrl #(
    .SEEN_DEPTH(SEEN_DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .own_addr    (own_addr),
    .in_req      (in_req),
    .out_rsp     (out_rsp),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  fdff_seen_mem #(
    .SEEN_DEPTH(SEEN_DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

endmodule

/* verif/flood_duplicate_filter_forwarder_top_tb.sv */
module flood_duplicate_filter_forwarder_top_tb;

  localparam int SEEN_DEPTH = fdff_pkg::DEFAULT_SEEN_DEPTH;
  localparam int MAX_GAP = 16;
  localparam int SETTLE_CYCLES = 16;
  // Longest quiet stretch: full cache scan plus both sides idling, taken 4x
  localparam int QUIET_LIMIT = 4 * (SEEN_DEPTH + 4 + 2 * MAX_GAP);
  localparam int HIST_DEPTH = 2 * SEEN_DEPTH;
  localparam int RANDOM_PER_PHASE = 204;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [47:0] cfg_wr_data = '0;

  fdff_chan_if #(.payload_t(fdff_pkg::in_payload_t))  req_ch ();
  fdff_chan_if #(.payload_t(fdff_pkg::out_payload_t)) rsp_ch ();

  flood_duplicate_filter_forwarder_top #(
    .SEEN_DEPTH(SEEN_DEPTH)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_req     (req_ch),
    .out_rsp    (rsp_ch)
  );

  always #6 clk = ~clk;

  // Mirror of the node state
  logic [47:0]  node_addr = '0;
  logic [47:0]  cache_origin [SEEN_DEPTH];
  logic [31:0]  cache_seq [SEEN_DEPTH];
  int unsigned  cache_fill = 0;
  int unsigned  evict_ptr = 0;
  logic [31:0]  dup_total = '0;

  fdff_pkg::out_payload_t pending_verdicts [$];
  fdff_pkg::seen_entry_t  pair_hist [$];
  int unsigned  mismatch_count = 0;
  int unsigned  quiet_cycles = 0;
  bit           src_burst = 1'b0;
  bit           sink_burst = 1'b0;

  function automatic logic [47:0] rand48();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[47:0];
  endfunction

  function automatic int unsigned draw_gap(bit burst);
    return burst ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // Fill slots in order, then overwrite at the wrapping pointer
  function automatic void remember_pair(logic [47:0] origin, logic [31:0] seq);
    int unsigned slot;
    if (cache_fill < SEEN_DEPTH) begin
      slot = cache_fill;
      cache_fill = cache_fill + 1;
    end else begin
      slot = evict_ptr;
      evict_ptr = (evict_ptr + 1) % SEEN_DEPTH;
    end
    cache_origin[slot] = origin;
    cache_seq[slot] = seq;
  endfunction

  function automatic bit pair_cached(logic [47:0] origin, logic [31:0] seq);
    for (int unsigned i = 0; i < cache_fill; i++) begin
      if (cache_origin[i] == origin && cache_seq[i] == seq) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Judge one frame request and advance the node state
  function automatic fdff_pkg::out_payload_t judge_frame(fdff_pkg::in_payload_t f);
    fdff_pkg::out_payload_t r;
    r = '0;
    r.verdict = fdff_pkg::VERDICT_INVALID;
    if (f.kind == fdff_pkg::KIND_ORIG) begin
      remember_pair(f.origin_addr, f.sequence_req);
      r.verdict = fdff_pkg::VERDICT_ORIG;
    end else if (f.marker != fdff_pkg::VALID_MARKER ||
                 f.frame_len > fdff_pkg::MAX_PAYLOAD) begin
      r.verdict = fdff_pkg::VERDICT_INVALID;
    end else if (pair_cached(f.origin_addr, f.sequence_req)) begin
      dup_total = dup_total + 32'd1;
      r.verdict = fdff_pkg::VERDICT_DUP;
    end else begin
      remember_pair(f.origin_addr, f.sequence_req);
      r.verdict = fdff_pkg::VERDICT_ACCEPT;
      if (f.dest_addr == node_addr && f.frame_len >= fdff_pkg::WORD_BYTES) begin
        r.deliver = 1'b1;
        r.delivered_seq = f.payload_word;
      end
      if (f.hop_limit > fdff_pkg::MIN_HOP_FWD) begin
        r.forward = 1'b1;
        r.forward_hop_limit = f.hop_limit - 8'd1;
      end
    end
    r.duplicate_count = dup_total;
    return r;
  endfunction

  function automatic fdff_pkg::in_payload_t make_frame(logic kind, logic [7:0] marker,
                                             logic [7:0] hop, logic [47:0] origin,
                                             logic [47:0] dest, logic [31:0] seq,
                                             logic [15:0] flen, logic [31:0] word);
    fdff_pkg::in_payload_t f;
    f.kind = kind;
    f.marker = marker;
    f.hop_limit = hop;
    f.origin_addr = origin;
    f.dest_addr = dest;
    f.sequence_req = seq;
    f.frame_len = flen;
    f.payload_word = word;
    return f;
  endfunction

  // Mostly well-formed frames, often replaying a recent pair to hit the cache
  function automatic fdff_pkg::in_payload_t rand_frame();
    fdff_pkg::in_payload_t f;
    fdff_pkg::seen_entry_t p;
    int unsigned pick;
    int unsigned len_pick;
    pick = $urandom_range(0, 9);
    if (pick < 4 && pair_hist.size() != 0) begin
      p = pair_hist[$urandom_range(0, pair_hist.size() - 1)];
    end else begin
      p.origin = (pick < 7) ? (48'h0F0F_A5A5_0000 | 48'($urandom_range(0, 7))) : rand48();
      p.seq = $urandom();
    end
    f.kind = ($urandom_range(0, 11) == 0) ? fdff_pkg::KIND_ORIG : fdff_pkg::KIND_RECV;
    f.marker = ($urandom_range(0, 9) == 0) ? 8'($urandom()) : fdff_pkg::VALID_MARKER;
    f.hop_limit = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 2)) : 8'($urandom());
    f.origin_addr = p.origin;
    f.sequence_req = p.seq;
    f.dest_addr = ($urandom_range(0, 1) == 0) ? node_addr : rand48();
    len_pick = $urandom_range(0, 19);
    if (len_pick < 16) f.frame_len = 16'($urandom_range(0, 24));
    else if (len_pick < 18) f.frame_len = 16'($urandom_range(25, 40));
    else f.frame_len = 16'($urandom());
    f.payload_word = $urandom();
    return f;
  endfunction

  // Drive one request; called and returns at a falling edge
  task automatic send_frame(fdff_pkg::in_payload_t f);
    int unsigned gap;
    fdff_pkg::seen_entry_t p;
    gap = draw_gap(src_burst);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.payload <= f;
    req_ch.valid <= 1'b1;
    do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
    pending_verdicts.push_back(judge_frame(f));
    p.origin = f.origin_addr;
    p.seq = f.sequence_req;
    pair_hist.push_back(p);
    if (pair_hist.size() > HIST_DEPTH) void'(pair_hist.pop_front());
    @(negedge clk);
  endtask

  // Hold requests until every expected result is back
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_own_addr(logic [47:0] addr);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= addr;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    node_addr = addr;
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // Field extremes, every verdict and the special cases
  task automatic test_directed_frames();
    logic [47:0] ones48;
    logic [47:0] orig_a;
    ones48 = '1;
    orig_a = 48'h1234_5678_9ABC;
    src_burst = 1'b0;
    sink_burst = 1'b0;
    // Reset address still zero: deliver, then duplicate
    send_frame(make_frame(fdff_pkg::KIND_RECV, fdff_pkg::VALID_MARKER, 8'd2, '0, '0, '0,
                          16'd4, 32'hDEAD_BEEF));
    send_frame(make_frame(fdff_pkg::KIND_RECV, fdff_pkg::VALID_MARKER, 8'd2, '0, '0, '0,
                          16'd4, 32'hDEAD_BEEF));
    write_own_addr(ones48);
    // Bad marker or oversize payload
    send_frame(make_frame(fdff_pkg::KIND_RECV, 8'hF0, 8'd5, rand48(), ones48, $urandom(),
                          16'd4, '1));
    send_frame(make_frame(fdff_pkg::KIND_RECV, 8'h00, 8'd5, rand48(), ones48, $urandom(),
                          16'd4, '1));
    send_frame(make_frame(fdff_pkg::KIND_RECV, 8'hFF, 8'd5, rand48(), ones48, $urandom(),
                          16'd4, '1));
    send_frame(make_frame(fdff_pkg::KIND_RECV, fdff_pkg::VALID_MARKER, 8'd5, rand48(),
                          ones48, $urandom(), 16'd25, '1));
    send_frame(make_frame(fdff_pkg::KIND_RECV, fdff_pkg::VALID_MARKER, 8'd5, rand48(),
                          ones48, $urandom(), 16'hFFFF, '1));
    // All-ones frame, max payload, max hop
    send_frame(make_frame(fdff_pkg::KIND_RECV, fdff_pkg::VALID_MARKER, 8'hFF, ones48,
                          ones48, '1, 16'd24, '1));
    // Short payloads, hop limits that stop forwarding, and a frame for another node
    send_frame(make_frame(fdff_pkg::KIND_RECV, fdff_pkg::VALID_MARKER, 8'd1, rand48(),
                          ones48, $urandom(), 16'd3, $urandom()));
    send_frame(make_frame(fdff_pkg::KIND_RECV, fdff_pkg::VALID_MARKER, 8'd0, rand48(),
                          ones48, $urandom(), 16'd0, $urandom()));
    send_frame(make_frame(fdff_pkg::KIND_RECV, fdff_pkg::VALID_MARKER, 8'd3, rand48(),
                          '0, $urandom(), 16'd4, $urandom()));
    // Originate stores even when already present; later receive is a duplicate
    send_frame(make_frame(fdff_pkg::KIND_ORIG, 8'h00, 8'h00, orig_a, rand48(),
                          32'h0000_0042, 16'hFFFF, '1));
    send_frame(make_frame(fdff_pkg::KIND_ORIG, 8'hFF, 8'hFF, orig_a, ones48,
                          32'h0000_0042, '0, '0));
    send_frame(make_frame(fdff_pkg::KIND_RECV, fdff_pkg::VALID_MARKER, 8'd9, orig_a,
                          ones48, 32'h0000_0042, 16'd8, $urandom()));
    send_frame(make_frame(fdff_pkg::KIND_ORIG, 8'h00, 8'h00, ones48, '0, '1, '0, '0));
    // Invalid frame with a cached pair is not counted
    send_frame(make_frame(fdff_pkg::KIND_RECV, 8'hF2, 8'd9, ones48, ones48, '1, 16'd8,
                          $urandom()));
    // Same origin or same sequence alone is not a match; the full pair is
    send_frame(make_frame(fdff_pkg::KIND_RECV, fdff_pkg::VALID_MARKER, 8'd9, ones48,
                          ones48, 32'hFFFF_FFFE, 16'd8, $urandom()));
    send_frame(make_frame(fdff_pkg::KIND_RECV, fdff_pkg::VALID_MARKER, 8'd9,
                          48'hFFFF_FFFF_FFFE, ones48, '1, 16'd8, $urandom()));
    send_frame(make_frame(fdff_pkg::KIND_RECV, fdff_pkg::VALID_MARKER, 8'd9, ones48,
                          ones48, '1, 16'd24, '0));
  endtask

  // Overflow the cache so the oldest pairs are overwritten
  task automatic test_cache_wrap();
    write_own_addr(rand48());
    src_burst = 1'b1;
    sink_burst = 1'b1;
    for (int i = 0; i < SEEN_DEPTH + 8; i++) begin
      send_frame(make_frame(fdff_pkg::KIND_ORIG, 8'($urandom()), 8'($urandom()),
                            {16'h5A5A, 32'(i)}, rand48(), ~32'(i), 16'($urandom()),
                            $urandom()));
    end
    src_burst = 1'b0;
    sink_burst = 1'b0;
    // Evicted pairs come back as new; the latest ones are still duplicates
    for (int i = 0; i < 4; i++) begin
      send_frame(make_frame(fdff_pkg::KIND_RECV, fdff_pkg::VALID_MARKER, 8'd7,
                            {16'h5A5A, 32'(i)}, node_addr, ~32'(i), 16'd12, $urandom()));
    end
    for (int i = SEEN_DEPTH + 4; i < SEEN_DEPTH + 8; i++) begin
      send_frame(make_frame(fdff_pkg::KIND_RECV, fdff_pkg::VALID_MARKER, 8'd7,
                            {16'h5A5A, 32'(i)}, node_addr, ~32'(i), 16'd12, $urandom()));
    end
  endtask

  // Random traffic under several node addresses
  task automatic test_random_traffic();
    logic [47:0] addrs [3];
    addrs[0] = '0;
    addrs[1] = rand48();
    addrs[2] = '1;
    foreach (addrs[ph]) begin
      write_own_addr(addrs[ph]);
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (n % 40 == 0) begin
          src_burst = ($urandom_range(0, 3) == 0);
          sink_burst = ($urandom_range(0, 3) == 0);
        end
        // Now and then let everything drain before the next request
        if ($urandom_range(0, 63) == 0) wait_idle();
        send_frame(rand_frame());
      end
    end
    wait_idle();
  endtask

  // Response side: stall a random number of cycles after each result, none in a burst
  initial begin : rsp_sink
    int unsigned stall;
    rsp_ch.ready = 1'b0;
    wait (!rst);
    @(negedge clk);
    rsp_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (rsp_ch.valid && rsp_ch.ready) begin
        @(negedge clk);
        stall = draw_gap(sink_burst);
        if (stall != 0) begin
          rsp_ch.ready <= 1'b0;
          repeat (stall) @(negedge clk);
          rsp_ch.ready <= 1'b1;
        end
      end
    end
  end

  // Compare each result with the oldest expected verdict
  always @(posedge clk) begin : rsp_check
    fdff_pkg::out_payload_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_verdicts.size() == 0) begin
        $error("result with no request outstanding: 0x%0h", rsp_ch.payload);
        mismatch_count++;
      end else begin
        want = pending_verdicts.pop_front();
        check_field("verdict", 32'(want.verdict), 32'(rsp_ch.payload.verdict));
        check_field("deliver", 32'(want.deliver), 32'(rsp_ch.payload.deliver));
        check_field("delivered_seq", want.delivered_seq, rsp_ch.payload.delivered_seq);
        check_field("forward", 32'(want.forward), 32'(rsp_ch.payload.forward));
        check_field("forward_hop_limit", 32'(want.forward_hop_limit),
                    32'(rsp_ch.payload.forward_hop_limit));
        check_field("duplicate_count", want.duplicate_count,
                    rsp_ch.payload.duplicate_count);
      end
    end
  end

  // Stop the run when neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("flood_duplicate_filter_forwarder_top: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.payload = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_frames();
    test_cache_wrap();
    test_random_traffic();
    if (mismatch_count == 0) begin
      $display("flood_duplicate_filter_forwarder_top: match");
    end else begin
      $display("flood_duplicate_filter_forwarder_top: mismatch");
    end
    $finish;
  end

endmodule
